[hw/rtl/acd_pkg.sv]
`timescale 1ns / 1ps

package acd_pkg;

    // Fixed field widths of the channels.
    localparam int OP_W       = 1;
    localparam int SAMPLE_W   = 4;
    localparam int RESULT_W   = 4;
    localparam int THRESH_W   = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_ON_CONFIRM  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_CONFIRM = 8'd1;

    // Control shared by every leg for the beat being processed.
    typedef struct packed {
        logic advance;
        logic restart;
        logic primed;
    } t_leg_ctl;

endpackage

[hw/rtl/acd_if.sv]
`timescale 1ns / 1ps

interface acd_sample_if;
    logic                         valid;
    logic                         ready;
    logic [acd_pkg::OP_W-1:0]     operation;
    logic [acd_pkg::SAMPLE_W-1:0] contact_sample;

    modport source (output valid, output operation, output contact_sample, input ready);
    modport sink   (input valid, input operation, input contact_sample, output ready);
endinterface

interface acd_result_if;
    logic                         valid;
    logic                         ready;
    logic [acd_pkg::RESULT_W-1:0] debounced_contacts;

    modport source (output valid, output debounced_contacts, input ready);
    modport sink   (input valid, input debounced_contacts, output ready);
endinterface

interface acd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [acd_pkg::CFG_IDX_W-1:0]  index;
    logic [acd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/acd_leg.sv]
`timescale 1ns / 1ps

module acd_leg #(
    parameter int COUNT_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  acd_pkg::t_leg_ctl             i_ctl,
    input  logic                          i_raw,
    input  logic [acd_pkg::THRESH_W-1:0]  i_on_th,
    input  logic [acd_pkg::THRESH_W-1:0]  i_off_th,
    output logic                          o_next_flag
);
    import acd_pkg::*;

    localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  r_flag;
    logic [COUNT_BITS-1:0] r_rise;
    logic [COUNT_BITS-1:0] r_fall;
    logic                  n_flag;
    logic [COUNT_BITS-1:0] n_rise;
    logic [COUNT_BITS-1:0] n_fall;

    logic [THRESH_W-1:0]   on_eff;
    logic [THRESH_W-1:0]   off_eff;
    logic [COUNT_BITS-1:0] rise_inc;
    logic [COUNT_BITS-1:0] fall_inc;

    // A threshold of zero behaves as one.
    assign on_eff  = (i_on_th  == '0) ? THRESH_W'(1) : i_on_th;
    assign off_eff = (i_off_th == '0) ? THRESH_W'(1) : i_off_th;

    assign rise_inc = (r_rise == COUNT_MAX) ? COUNT_MAX : r_rise + COUNT_BITS'(1);
    assign fall_inc = (r_fall == COUNT_MAX) ? COUNT_MAX : r_fall + COUNT_BITS'(1);

    always_comb begin
        n_flag = r_flag;
        n_rise = r_rise;
        n_fall = r_fall;
        if (i_ctl.restart) begin
            n_flag = 1'b0;
            n_rise = '0;
            n_fall = '0;
        end else if (!i_ctl.primed) begin
            // The first sample is taken over as is.
            n_flag = i_raw;
            n_rise = '0;
            n_fall = '0;
        end else if (i_raw == r_flag) begin
            n_rise = '0;
            n_fall = '0;
        end else if (i_raw) begin
            n_fall = '0;
            n_rise = rise_inc;
            if (CMP_W'(rise_inc) >= CMP_W'(on_eff)) begin
                n_flag = 1'b1;
                n_rise = '0;
            end
        end else begin
            n_rise = '0;
            n_fall = fall_inc;
            if (CMP_W'(fall_inc) >= CMP_W'(off_eff)) begin
                n_flag = 1'b0;
                n_fall = '0;
            end
        end
    end

    assign o_next_flag = n_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
            r_rise <= '0;
            r_fall <= '0;
        end else if (i_ctl.advance) begin
            r_flag <= n_flag;
            r_rise <= n_rise;
            r_fall <= n_fall;
        end
    end

endmodule

[hw/rtl/asymmetric_contact_debouncer_unit.sv]
`timescale 1ns / 1ps

// Channel        Direction  Payload
// i_sample_if    in         operation, contact_sample
// o_result_if    out        debounced_contacts
// i_cfg_if       in         index, data (0 = on confirm, 1 = off confirm)
//
// One beat in, one beat out; a new sample is taken every cycle unless the result is stalled.
// A sample passes through an input register, then the per-leg compare and
// count logic feeding the result register.
// Reset restores both thresholds to 1 and clears flags, counters and primed.
// A stalled result holds the pipeline; the input register still fills.
module asymmetric_contact_debouncer_unit #(
    parameter int NUM_LEGS   = 4,
    parameter int COUNT_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    acd_sample_if.sink   i_sample_if,
    acd_result_if.source o_result_if,
    acd_cfg_if.sink      i_cfg_if
);
    import acd_pkg::*;

    logic [THRESH_W-1:0] r_on_th;
    logic [THRESH_W-1:0] r_off_th;

    logic                r_in_valid;
    t_op                 r_op;
    logic [SAMPLE_W-1:0] r_sample;

    logic                r_primed;
    logic                r_out_valid;
    logic [RESULT_W-1:0] r_out_data;

    logic                out_free;
    logic                advance;
    t_leg_ctl            leg_ctl;
    logic [NUM_LEGS-1:0] next_flags;
    logic [RESULT_W-1:0] n_out_data;

    assign i_cfg_if.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_th  <= THRESH_W'(1);
            r_off_th <= THRESH_W'(1);
        end else if (i_cfg_if.valid) begin
            unique case (i_cfg_if.index)
                REG_ON_CONFIRM:  r_on_th  <= i_cfg_if.data;
                REG_OFF_CONFIRM: r_off_th <= i_cfg_if.data;
                default: ;
            endcase
        end
    end

    assign out_free          = !r_out_valid || o_result_if.ready;
    assign advance           = r_in_valid && out_free;
    assign i_sample_if.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample_if.ready) begin
            r_in_valid <= i_sample_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample_if.valid && i_sample_if.ready) begin
            r_op     <= t_op'(i_sample_if.operation);
            r_sample <= i_sample_if.contact_sample;
        end
    end

    assign leg_ctl.advance = advance;
    assign leg_ctl.restart = (r_op == OP_RESTART);
    assign leg_ctl.primed  = r_primed;

    genvar g;
    generate
        for (g = 0; g < NUM_LEGS; g++) begin : g_leg
            logic raw_bit;
            if (g < SAMPLE_W) begin : g_in
                assign raw_bit = r_sample[g];
            end else begin : g_none
                assign raw_bit = 1'b0;
            end

            acd_leg #(
                .COUNT_BITS (COUNT_BITS)
            ) u_leg (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (leg_ctl),
                .i_raw       (raw_bit),
                .i_on_th     (r_on_th),
                .i_off_th    (r_off_th),
                .o_next_flag (next_flags[g])
            );
        end

        for (g = 0; g < RESULT_W; g++) begin : g_out
            if (g < NUM_LEGS) begin : g_leg_bit
                assign n_out_data[g] = next_flags[g];
            end else begin : g_pad
                assign n_out_data[g] = 1'b0;
            end
        end
    endgenerate

    // Any sample primes the block; a restart clears the mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (advance) begin
            r_primed <= (r_op != OP_RESTART);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_result_if.valid              = r_out_valid;
    assign o_result_if.debounced_contacts = r_out_data;

endmodule
